@@ rtl/lce_pkg.sv @@
// ----------------------------------------------------------------------------
// lce_pkg
// Shared types and constants for the line code encoder.
// ----------------------------------------------------------------------------
package lce_pkg;

    localparam int BURST_MAX = 8;                      // most symbols from one item
    localparam int BURST_IDX_W = $clog2(BURST_MAX);
    localparam int BURST_CNT_W = $clog2(BURST_MAX + 1);

    typedef logic signed [1:0] t_level;

    localparam t_level LVL_POS  = 2'sb01;
    localparam t_level LVL_ZERO = 2'sb00;
    localparam t_level LVL_NEG  = 2'sb11;

    typedef enum logic [2:0] {
        MODE_NRZL   = 3'd0,
        MODE_NRZI   = 3'd1,
        MODE_AMI    = 3'd2,
        MODE_MANCH  = 3'd3,
        MODE_DMANCH = 3'd4,
        MODE_B8ZS   = 3'd5,
        MODE_HDB3   = 3'd6
    } t_code_mode;

    typedef struct packed {
        t_level second;
        t_level first;
    } t_symbol;

    typedef struct packed {
        logic [2:0] held_zero_count;
        logic       last_mark_positive;
        logic       reference_level_high;
        logic       marks_since_violation_odd;
    } t_stream_state;

    function automatic t_level pol(input logic positive);
        return positive ? LVL_POS : LVL_NEG;
    endfunction

    function automatic t_stream_state clear_state(input t_code_mode mode);
        t_stream_state s;
        s.held_zero_count           = 3'd0;
        s.last_mark_positive        = (mode == MODE_B8ZS);
        s.reference_level_high      = 1'b0;
        s.marks_since_violation_odd = 1'b0;
        return s;
    endfunction

endpackage

@@ rtl/lce_burst_gen.sv @@
// ----------------------------------------------------------------------------
// lce_burst_gen
// Encodes one data bit into a burst of up to eight line symbols and works out
// the stream state that follows it.
// ----------------------------------------------------------------------------
module lce_burst_gen
    import lce_pkg::*;
(
    input  t_code_mode               i_mode,
    input  t_stream_state            i_state,
    input  logic                     i_data_bit,
    input  logic                     i_end_of_stream,
    output t_symbol                  o_burst [BURST_MAX],
    output logic [BURST_CNT_W-1:0]   o_count,
    output t_stream_state            o_state
);

    t_stream_state        ns;
    t_symbol              sym [BURST_MAX];
    logic [BURST_CNT_W-1:0] n;
    logic                 first_high;
    t_level               p;
    t_level               np;

    always_comb begin
        ns         = i_state;
        n          = '0;
        first_high = 1'b0;
        p          = pol(i_state.last_mark_positive);
        np         = pol(!i_state.last_mark_positive);
        for (int i = 0; i < BURST_MAX; i++) begin
            sym[i] = '{second: LVL_ZERO, first: LVL_ZERO};
        end

        unique case (i_mode)
            MODE_NRZI: begin
                ns.reference_level_high = i_state.reference_level_high ^ i_data_bit;
                sym[0] = '{second: pol(ns.reference_level_high),
                           first:  pol(ns.reference_level_high)};
                n = BURST_CNT_W'(1);
            end
            MODE_AMI: begin
                if (i_data_bit) begin
                    ns.last_mark_positive = !i_state.last_mark_positive;
                    sym[0] = '{second: np, first: np};
                end
                n = BURST_CNT_W'(1);
            end
            MODE_MANCH: begin
                if (i_data_bit) begin
                    sym[0] = '{second: LVL_NEG, first: LVL_POS};
                end else begin
                    sym[0] = '{second: LVL_POS, first: LVL_NEG};
                end
                n = BURST_CNT_W'(1);
            end
            MODE_DMANCH: begin
                first_high = i_data_bit ? i_state.reference_level_high
                                        : !i_state.reference_level_high;
                sym[0] = '{second: pol(!first_high), first: pol(first_high)};
                ns.reference_level_high = !first_high;
                n = BURST_CNT_W'(1);
            end
            MODE_B8ZS, MODE_HDB3: begin
                if (i_data_bit) begin
                    // held zeros are already zero symbols; the mark follows them
                    ns.last_mark_positive = !i_state.last_mark_positive;
                    for (int i = 0; i < BURST_MAX; i++) begin
                        if (i_state.held_zero_count == BURST_IDX_W'(i)) begin
                            sym[i] = '{second: np, first: np};
                        end
                    end
                    n = BURST_CNT_W'(i_state.held_zero_count) + BURST_CNT_W'(1);
                    ns.held_zero_count = 3'd0;
                    if (i_mode == MODE_HDB3) begin
                        ns.marks_since_violation_odd = !i_state.marks_since_violation_odd;
                    end
                end else if (i_mode == MODE_B8ZS && i_state.held_zero_count == 3'd7) begin
                    // 000VB0VB
                    sym[3] = '{second: p,  first: p};
                    sym[4] = '{second: np, first: np};
                    sym[6] = '{second: np, first: np};
                    sym[7] = '{second: p,  first: p};
                    n = BURST_CNT_W'(8);
                    ns.held_zero_count = 3'd0;
                end else if (i_mode == MODE_HDB3 && i_state.held_zero_count >= 3'd3) begin
                    if (i_state.marks_since_violation_odd) begin
                        // 000V
                        sym[3] = '{second: p, first: p};
                    end else begin
                        // B00V
                        ns.last_mark_positive = !i_state.last_mark_positive;
                        sym[0] = '{second: np, first: np};
                        sym[3] = '{second: np, first: np};
                    end
                    n = BURST_CNT_W'(4);
                    ns.held_zero_count = 3'd0;
                    ns.marks_since_violation_odd = 1'b0;
                end else begin
                    ns.held_zero_count = i_state.held_zero_count + 3'd1;
                end
            end
            default: begin
                // NRZ-L, also for the unused mode code
                if (i_data_bit) begin
                    sym[0] = '{second: LVL_POS, first: LVL_POS};
                end else begin
                    sym[0] = '{second: LVL_NEG, first: LVL_NEG};
                end
                n = BURST_CNT_W'(1);
            end
        endcase

        if (i_end_of_stream) begin
            // still-held zeros go out as zero symbols after this bit's output
            n  = n + BURST_CNT_W'(ns.held_zero_count);
            ns = clear_state(i_mode);
        end
    end

    assign o_burst = sym;
    assign o_count = n;
    assign o_state = ns;

endmodule

@@ rtl/line_code_encoder.sv @@
// ----------------------------------------------------------------------------
// line_code_encoder
// Multi-mode line encoder: NRZ-L, NRZ-I, AMI, Manchester, differential
// Manchester, B8ZS and HDB3, one data bit per input item.
// ----------------------------------------------------------------------------
// Each accepted bit is encoded in the cycle it arrives into a burst of zero to
// eight symbols, which loads a symbol shift register; the output side drains
// it one symbol per cycle while m_axis_tready is high. A bit is accepted when
// that register is empty or its final symbol is taken in the same cycle, so a
// one-symbol bit passes at one item per cycle unless the output stalls, a bit
// of more symbols holds the input until its last is taken, and a bit that only
// adds to a held zero run makes none. Write code_mode only while no symbols are
// pending; a write clears the held zeros and the polarity and parity state.
// ----------------------------------------------------------------------------
module line_code_encoder
    import lce_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [2:0] i_cfg_wr_data,   // code_mode
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,    // [0] data_bit, [7:1] zero
    input  logic       s_axis_tlast,    // end_of_stream
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,    // [1:0] level_first, [3:2] level_second, [7:4] zero
    output logic       m_axis_tlast     // last_of_run
);

    t_code_mode             r_mode;
    t_stream_state          r_state;
    t_symbol                r_sym [BURST_MAX];
    logic [BURST_CNT_W-1:0] r_cnt;

    t_symbol                gen_burst [BURST_MAX];
    logic [BURST_CNT_W-1:0] gen_count;
    t_stream_state          gen_state;
    logic                   in_accept;
    logic                   out_take;

    lce_burst_gen u_burst_gen (
        .i_mode          (r_mode),
        .i_state         (r_state),
        .i_data_bit      (s_axis_tdata[0]),
        .i_end_of_stream (s_axis_tlast),
        .o_burst         (gen_burst),
        .o_count         (gen_count),
        .o_state         (gen_state)
    );

    assign m_axis_tvalid = (r_cnt != '0);
    assign m_axis_tlast  = (r_cnt == BURST_CNT_W'(1));
    assign m_axis_tdata  = {4'b0000, r_sym[0].second, r_sym[0].first};
    assign out_take      = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (r_cnt == '0) || (m_axis_tlast && m_axis_tready);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // mode and stream state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_NRZL;
            r_state <= clear_state(MODE_NRZL);
        end else if (i_cfg_wr_en) begin
            r_mode  <= t_code_mode'(i_cfg_wr_data);
            r_state <= clear_state(t_code_mode'(i_cfg_wr_data));
        end else if (in_accept) begin
            r_state <= gen_state;
        end
    end

    // symbol count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (in_accept) begin
            r_cnt <= gen_count;
        end else if (out_take) begin
            r_cnt <= r_cnt - BURST_CNT_W'(1);
        end
    end

    // symbol shift register, head at index 0
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_sym <= gen_burst;
        end else if (out_take) begin
            for (int i = 0; i < BURST_MAX - 1; i++) begin
                r_sym[i] <= r_sym[i+1];
            end
        end
    end

endmodule
